>>> src/adts_pkg.sv
// Package for the ADTS frame deframer: shared types and constants.
// Used by adts_parse, adts_outq and adts_frame_deframer; depends on nothing.
package adts_pkg;

  localparam int HDR_LEN   = 7;
  localparam int LEN_W     = 14;
  localparam int OQ_DEPTH  = 8;
  localparam int OQ_AW     = $clog2(OQ_DEPTH);
  localparam int OQ_CW     = $clog2(OQ_DEPTH + 1);

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [3:0] SYNC_NIB  = 4'hF;

  // Configuration register indexes
  localparam logic [7:0] CFG_MAX_FRAME_LEN = 8'd0;
  localparam logic [7:0] CFG_CRC_ADJUST    = 8'd1;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 14'd6144;

  typedef struct packed {
    logic [LEN_W-1:0] max_frame_len;
    logic             crc_length_adjust;
  } adts_cfg_t;

  // One queue entry: a single result beat, or a whole accepted header
  // (burst) that unrolls into HDR_LEN beats on the output side.
  typedef struct packed {
    logic [HDR_LEN-1:0][7:0] bytes;
    logic                    burst;
    logic                    start;
    logic                    last;
    logic                    drop;
  } adts_tok_t;

endpackage

>>> src/adts_frame_deframer.sv
// ADTS frame deframer top level: config registers, parser and result queue.
// Takes one byte per cycle while the queue has space; each result beat is queued
// and then registered. A header leaves as seven beats, one per cycle unless the
// output stalls; an eight-entry parser-to-output queue absorbs header bursts.
// Synchronous active-low reset: hunting, queue empty, limit 6144, CRC adjust on.
// Depends on adts_pkg, adts_parse, adts_outq.
module adts_frame_deframer import adts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // Input byte stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // [7:0] out_byte
  output logic         out_tlast,  // frame_last
  output logic [1:0]   out_tuser,  // [0] frame_start, [1] header_dropped
  // Configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [LEN_W-1:0] cfg_data
);

  adts_cfg_t cfg_r;
  logic      acc;
  logic      push;
  logic      space;
  adts_tok_t tok;

  assign cfg_ready = 1'b1;
  assign in_tready = space;
  assign acc       = in_tvalid && space;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_len     <= MAX_LEN_RESET;
      cfg_r.crc_length_adjust <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MAX_FRAME_LEN) begin
        cfg_r.max_frame_len <= cfg_data;
      end else if (cfg_index == CFG_CRC_ADJUST) begin
        cfg_r.crc_length_adjust <= cfg_data[0];
      end
    end
  end

  adts_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .acc       (acc),
    .data_byte (in_tdata),
    .push      (push),
    .tok       (tok)
  );

  adts_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .tok            (tok),
    .space          (space),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (out_tdata),
    .frame_start    (out_tuser[0]),
    .frame_last     (out_tlast),
    .header_dropped (out_tuser[1])
  );

endmodule

>>> src/adts_parse.sv
// ADTS sync hunt and header/body parser; emits at most one queue entry per byte.
// Depends on adts_pkg.
module adts_parse import adts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  adts_cfg_t  cfg,
  input  logic       acc,
  input  logic [7:0] data_byte,
  output logic       push,
  output adts_tok_t  tok
);

  typedef enum logic [1:0] {
    MODE_HUNT   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_BODY   = 2'd2
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic             ff_r, ff_nxt;
  logic [2:0]       cnt_r, cnt_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [7:0]       hdr_r [HDR_LEN];

  logic [LEN_W-1:0] size;
  logic [LEN_W-1:0] rem_dec;
  logic             sync_hit;
  logic             hdr_done;

  // Frame length from header bytes 3..5, plus optional CRC adjust
  always_comb begin
    size = {1'b0, hdr_r[3][1:0], hdr_r[4], hdr_r[5][7:5]};
    if (cfg.crc_length_adjust && !hdr_r[1][0]) begin
      size = size + LEN_W'(2);
    end
  end

  assign rem_dec  = rem_r - LEN_W'(1);
  assign sync_hit = ff_r && (data_byte[7:4] == SYNC_NIB);
  assign hdr_done = (cnt_r == 3'(HDR_LEN - 1));

  // Next state and result entry
  always_comb begin
    mode_nxt = mode_r;
    ff_nxt   = ff_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    push     = 1'b0;
    tok      = '0;
    unique case (mode_r)
      MODE_HEADER: begin
        cnt_nxt = cnt_r + 3'd1;
        if (hdr_done) begin
          push = 1'b1;
          if (size >= cfg.max_frame_len || size < LEN_W'(HDR_LEN)) begin
            tok.drop = 1'b1;
            mode_nxt = MODE_HUNT;
            ff_nxt   = 1'b0;
            cnt_nxt  = '0;
            rem_nxt  = '0;
          end else begin
            for (int i = 0; i < HDR_LEN - 1; i++) begin
              tok.bytes[i] = hdr_r[i];
            end
            tok.bytes[HDR_LEN-1] = data_byte;
            tok.burst = 1'b1;
            tok.start = 1'b1;
            tok.last  = (size == LEN_W'(HDR_LEN));
            ff_nxt    = 1'b0;
            cnt_nxt   = '0;
            if (size == LEN_W'(HDR_LEN)) begin
              mode_nxt = MODE_HUNT;
              rem_nxt  = '0;
            end else begin
              mode_nxt = MODE_BODY;
              rem_nxt  = size - LEN_W'(HDR_LEN);
            end
          end
        end
      end
      MODE_BODY: begin
        push          = 1'b1;
        tok.bytes[0]  = data_byte;
        tok.last      = (rem_dec == '0);
        rem_nxt       = rem_dec;
        if (rem_dec == '0) begin
          mode_nxt = MODE_HUNT;
          ff_nxt   = 1'b0;
          cnt_nxt  = '0;
        end
      end
      default: begin
        mode_nxt = MODE_HUNT;
        if (sync_hit) begin
          cnt_nxt  = 3'd2;
          ff_nxt   = 1'b0;
          mode_nxt = MODE_HEADER;
        end else begin
          ff_nxt = (data_byte == SYNC_BYTE);
        end
      end
    endcase
    push = push & acc;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HUNT;
      ff_r   <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      ff_r   <= ff_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
    end
  end

  // Header byte store
  always_ff @(posedge clk) begin
    if (acc) begin
      if (mode_r == MODE_HEADER) begin
        hdr_r[cnt_r] <= data_byte;
      end else if (mode_r != MODE_BODY && sync_hit) begin
        hdr_r[0] <= SYNC_BYTE;
        hdr_r[1] <= data_byte;
      end
    end
  end

endmodule

>>> src/adts_outq.sv
// Result queue and output register; unrolls header entries into seven beats.
// Depends on adts_pkg.
module adts_outq import adts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  adts_tok_t  tok,
  output logic       space,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       frame_start,
  output logic       frame_last,
  output logic       header_dropped
);

  localparam logic [2:0] BEAT_END = 3'(HDR_LEN - 1);

  adts_tok_t        mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  adts_tok_t        cur_r;
  logic             cur_vld_r;
  logic [2:0]       beat_r;

  logic fire, step, load;

  assign space = (cnt_r != OQ_CW'(OQ_DEPTH));
  assign fire  = cur_vld_r && out_ready;
  assign step  = fire && cur_r.burst && (beat_r != BEAT_END);
  assign load  = (!cur_vld_r || (fire && !step)) && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !load) begin
      cnt_nxt = cnt_r + OQ_CW'(1);
    end else if (!push && load) begin
      cnt_nxt = cnt_r - OQ_CW'(1);
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= tok;
    end
    if (load) begin
      cur_r <= mem_r[rd_ptr_r];
    end
  end

  // Pointers, fill count and output beat control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      cur_vld_r <= 1'b0;
      beat_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OQ_AW'(1);
      end
      if (load) begin
        rd_ptr_r  <= rd_ptr_r + OQ_AW'(1);
        cur_vld_r <= 1'b1;
        beat_r    <= '0;
      end else if (step) begin
        beat_r <= beat_r + 3'd1;
      end else if (fire) begin
        cur_vld_r <= 1'b0;
      end
    end
  end

  // Beat fields
  assign out_valid      = cur_vld_r;
  assign out_byte       = cur_r.bytes[beat_r];
  assign frame_start    = cur_r.burst ? (beat_r == '0) : cur_r.start;
  assign frame_last     = cur_r.burst ? ((beat_r == BEAT_END) && cur_r.last) : cur_r.last;
  assign header_dropped = cur_r.drop;

endmodule

>>> tb/adts_frame_deframer_tb.sv
// Self-checking testbench for adts_frame_deframer: streams ADTS bytes under random
// bursts, stalls and register settings, and checks every output beat against a
// behavioral deframer kept in the bench. Depends on adts_pkg and the RTL only.
module adts_frame_deframer_tb;
  import adts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_ITEMS    = 300;
  localparam int          PHASE_ITEMS     = 60;
  localparam int          DRAIN_CYCLES    = 16;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          MAX_PRINTED     = 40;
  localparam int          CUT_MAX         = 32;
  localparam logic [7:0]  CFG_SPARE_INDEX = 8'hA7;

  typedef enum logic [1:0] {SEEK_SYNC, TAKE_HEADER, PASS_BODY} deframe_mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_last;
    logic       header_dropped;
  } frame_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = 8'h00;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic [1:0]        out_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        cfg_index = 8'h00;
  logic [LEN_W-1:0]  cfg_data = '0;

  adts_frame_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Register shadows, used by both the deframer model and the frame builder
  logic [LEN_W-1:0] limit_len  = MAX_LEN_RESET;
  logic             crc_adjust = 1'b1;

  // Deframer model state
  deframe_mode_t    mode = SEEK_SYNC;
  logic             ff_seen = 1'b0;
  logic [7:0]       hdr [HDR_LEN];
  int unsigned      hdr_cnt = 0;
  int unsigned      body_left = 0;

  logic [7:0]       stream_q [$];
  frame_beat_t      beats_due [$];

  int unsigned      bytes_queued = 0;
  int unsigned      bytes_accepted = 0;
  int unsigned      beats_checked = 0;
  int unsigned      frames_seen = 0;
  int unsigned      drops_seen = 0;
  int unsigned      settings = 1;
  int unsigned      mismatches = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("timeout: %0d beats still due, %0d bytes unsent", beats_due.size(),
             stream_q.size());
    $display("== FAIL ==");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Return the model to sync hunting after a frame or a rejected header
  task automatic resume_hunt();
    mode = SEEK_SYNC;
    ff_seen = 1'b0;
    hdr_cnt = 0;
    body_left = 0;
  endtask

  // Advance the deframer model by one stream byte and queue the beats it yields
  task automatic deframe_byte(input logic [7:0] b);
    int unsigned size;
    frame_beat_t beat;
    case (mode)
      TAKE_HEADER: begin
        hdr[hdr_cnt] = b;
        hdr_cnt++;
        if (hdr_cnt == HDR_LEN) begin
          size = 32'({hdr[3][1:0], hdr[4], hdr[5][7:5]});
          if (crc_adjust && !hdr[1][0]) size += 2;
          if (size >= limit_len || size < HDR_LEN) begin
            beat = '{out_byte: 8'h00, frame_start: 1'b0, frame_last: 1'b0,
                     header_dropped: 1'b1};
            beats_due.push_back(beat);
            resume_hunt();
          end else begin
            for (int i = 0; i < HDR_LEN; i++) begin
              beat = '{out_byte: hdr[i], frame_start: (i == 0),
                       frame_last: (i == HDR_LEN - 1) && (size == HDR_LEN),
                       header_dropped: 1'b0};
              beats_due.push_back(beat);
            end
            if (size == HDR_LEN) begin
              resume_hunt();
            end else begin
              mode = PASS_BODY;
              body_left = size - HDR_LEN;
              hdr_cnt = 0;
            end
          end
        end
      end
      PASS_BODY: begin
        body_left--;
        beat = '{out_byte: b, frame_start: 1'b0, frame_last: (body_left == 0),
                 header_dropped: 1'b0};
        beats_due.push_back(beat);
        if (body_left == 0) resume_hunt();
      end
      default: begin
        mode = SEEK_SYNC;
        if (ff_seen && b[7:4] == SYNC_NIB) begin
          hdr[0] = SYNC_BYTE;
          hdr[1] = b;
          hdr_cnt = 2;
          ff_seen = 1'b0;
          mode = TAKE_HEADER;
        end else begin
          ff_seen = (b == SYNC_BYTE);
        end
      end
    endcase
  endtask

  // Queue one ADTS frame; the body follows only when the header should pass
  task automatic queue_frame(input int unsigned flen, input logic [3:0] b1_low,
                             input logic [7:0] b6, input bit cut_body);
    logic [12:0] len13;
    logic [31:0] rnd;
    int unsigned size;
    int unsigned body;
    len13 = flen[12:0];
    rnd = $urandom;
    size = len13 + ((crc_adjust && !b1_low[0]) ? 2 : 0);
    stream_q.push_back(SYNC_BYTE);
    stream_q.push_back({SYNC_NIB, b1_low});
    stream_q.push_back(rnd[7:0]);
    stream_q.push_back({rnd[15:10], len13[12:11]});
    stream_q.push_back(len13[10:3]);
    stream_q.push_back({len13[2:0], rnd[20:16]});
    stream_q.push_back(b6);
    body = (size >= HDR_LEN && size < limit_len) ? size - HDR_LEN : 0;
    if (cut_body && body > 0)
      body = $urandom_range(0, (body > CUT_MAX) ? CUT_MAX - 1 : body - 1);
    repeat (body) stream_q.push_back(8'($urandom_range(0, 255)));
    bytes_queued += HDR_LEN + body;
  endtask

  // Queue a little line noise, then a frame with random shape and content
  task automatic queue_random_frame();
    int unsigned pick;
    int unsigned flen;
    repeat ($urandom_range(0, 2)) begin
      stream_q.push_back(8'($urandom_range(0, 254)));
      bytes_queued++;
    end
    if ($urandom_range(0, 9) == 0) begin
      // lone sync byte that is not followed by a sync nibble
      stream_q.push_back(SYNC_BYTE);
      stream_q.push_back(8'($urandom_range(0, 239)));
      bytes_queued += 2;
    end
    pick = $urandom_range(0, 99);
    if (pick < 10)      flen = $urandom_range(0, HDR_LEN - 1);
    else if (pick < 65) flen = $urandom_range(HDR_LEN, 30);
    else if (pick < 85) flen = limit_len - $urandom_range(0, 3);
    else                flen = $urandom_range(limit_len, 8191);
    queue_frame(flen, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                $urandom_range(0, 19) == 0);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [LEN_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_FRAME_LEN)   limit_len = val;
    else if (idx == CFG_CRC_ADJUST) crc_adjust = val[0];
  endtask

  task automatic set_limits(input logic [LEN_W-1:0] max_len, input logic adj);
    write_reg(CFG_MAX_FRAME_LEN, max_len);
    write_reg(CFG_CRC_ADJUST, {{(LEN_W-1){1'b0}}, adj});
    settings++;
  endtask

  // Wait until every byte is in and every beat out, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk); while (stream_q.size() != 0 || in_tvalid || beats_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        deframe_byte(in_tdata);
        bytes_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (stream_q.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= stream_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus long hold-offs
  int unsigned rx_mode = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done < 2 && in_tvalid && out_tvalid &&
                 beats_checked > 100 * (holds_done + 1)) begin
      hold_left = HOLD_CYCLES;
      holds_done++;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 128);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: compare each output beat with the oldest expected one
  frame_beat_t got;
  frame_beat_t want;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser[0], out_tlast, out_tuser[1]};
      beats_checked++;
      if (got.frame_start) frames_seen++;
      if (got.header_dropped) drops_seen++;
      if (beats_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data=%02h start=%0b last=%0b drop=%0b",
                                  got.out_byte, got.frame_start, got.frame_last,
                                  got.header_dropped));
      end else begin
        want = beats_due.pop_front();
        if (got.out_byte != want.out_byte)
          report_mismatch($sformatf("beat %0d data %02h, want %02h", beats_checked,
                                    got.out_byte, want.out_byte));
        if (got.frame_start != want.frame_start)
          report_mismatch($sformatf("beat %0d frame_start %0b, want %0b", beats_checked,
                                    got.frame_start, want.frame_start));
        if (got.frame_last != want.frame_last)
          report_mismatch($sformatf("beat %0d frame_last %0b, want %0b", beats_checked,
                                    got.frame_last, want.frame_last));
        if (got.header_dropped != want.header_dropped)
          report_mismatch($sformatf("beat %0d header_dropped %0b, want %0b", beats_checked,
                                    got.header_dropped, want.header_dropped));
      end
    end
  end

  // Stimulus sequence
  int unsigned rand_start;
  int unsigned phase_start;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limits: double sync byte with a seven-byte frame ending in 0xFF,
    // then a sync nibble that must not resync, short, CRC-adjusted and long headers
    stream_q.push_back(8'h00);
    bytes_queued++;
    queue_frame(HDR_LEN, 4'hF, 8'hFF, 1'b0);
    stream_q.push_back(8'hF0);
    bytes_queued++;
    queue_frame(HDR_LEN - 1, 4'h1, 8'h5A, 1'b0);
    queue_frame(HDR_LEN - 2, 4'h0, 8'hA5, 1'b0);
    queue_frame(7000, 4'h1, 8'h00, 1'b0);
    wait_idle();

    // Lowest limit; CRC adjust cleared by a wide value; a write to no register
    write_reg(CFG_MAX_FRAME_LEN, 14'd8);
    write_reg(CFG_CRC_ADJUST, 14'h3FFE);
    write_reg(CFG_SPARE_INDEX, 14'd7);
    settings++;
    queue_frame(8, 4'h1, 8'h11, 1'b0);
    queue_frame(HDR_LEN, 4'h0, 8'hEE, 1'b0);
    wait_idle();

    // Zero limit rejects every header
    set_limits(14'd0, 1'b1);
    queue_frame(HDR_LEN, 4'h1, 8'h33, 1'b0);
    queue_frame(20, 4'h0, 8'hCC, 1'b0);
    queue_frame(0, 4'h1, 8'hFF, 1'b0);
    wait_idle();

    // Random phases with small limits and random frames
    rand_start = bytes_queued;
    while (bytes_queued - rand_start < RANDOM_ITEMS) begin
      set_limits(LEN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(49, 200)
                                                    : $urandom_range(9, 48)),
                 1'($urandom_range(0, 1)));
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_ITEMS) queue_random_frame();
      wait_idle();
    end

    // Highest limit: longest length with CRC is just rejected, without CRC it passes
    // (that last body is cut short to keep the run brief)
    set_limits(14'd8193, 1'b1);
    queue_frame(8191, 4'h0, 8'h77, 1'b0);
    queue_frame(12, 4'h0, 8'h88, 1'b0);
    queue_frame(8191, 4'h1, 8'h99, 1'b1);
    wait_idle();

    $display("Run covered %0d stream bytes under %0d register settings.", bytes_accepted,
             settings);
    $display("Checked %0d output beats: %0d frames passed, %0d headers dropped.",
             beats_checked, frames_seen, drops_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
